/* design/dop_pkg.sv */
`timescale 1ns / 1ps

package dop_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CODE,
    PH_LEN,
    PH_DATA,
    PH_TYPEVAL,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK     = 4'd0,
    ST_OP     = 4'd1,
    ST_HTYPE  = 4'd2,
    ST_HLEN   = 4'd3,
    ST_XID    = 4'd4,
    ST_COOKIE = 4'd5,
    ST_OPTLEN = 4'd6,
    ST_TYPE   = 4'd7,
    ST_TRUNC  = 4'd8
  } status_t;

  localparam logic [31:0] COOKIE = 32'h6382_5363;

  // byte positions in the fixed header
  localparam logic [7:0] OFF_OP          = 8'd0;
  localparam logic [7:0] OFF_HTYPE       = 8'd1;
  localparam logic [7:0] OFF_HLEN        = 8'd2;
  localparam logic [7:0] OFF_XID_END     = 8'd7;
  localparam logic [7:0] OFF_YIADDR_END  = 8'd19;
  localparam logic [7:0] OFF_SIADDR_END  = 8'd23;
  localparam logic [7:0] OFF_COOKIE_END  = 8'd239;

  localparam logic [7:0] BOOTREPLY = 8'd2;
  localparam logic [7:0] HTYPE_ETH = 8'd1;
  localparam logic [7:0] HLEN_ETH  = 8'd6;

  localparam logic [7:0] OPT_PAD       = 8'd0;
  localparam logic [7:0] OPT_MASK      = 8'd1;
  localparam logic [7:0] OPT_ROUTER    = 8'd3;
  localparam logic [7:0] OPT_DNS       = 8'd6;
  localparam logic [7:0] OPT_LEASE     = 8'd51;
  localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0] OPT_SERVER_ID = 8'd54;
  localparam logic [7:0] OPT_END       = 8'd255;

  localparam logic [7:0] ADDR_OPT_LEN = 8'd4;
  localparam logic [7:0] MSG_TYPE_LEN = 8'd1;
  localparam logic [7:0] MSG_OFFER    = 8'd2;

  typedef struct packed {
    logic        hit;
    status_t     status;
    logic [31:0] offered_ip;
    logic [31:0] server_ip;
    logic [31:0] net_mask;
    logic [31:0] router_ip;
    logic [31:0] dns_server_ip;
  } res_t;

endpackage

/* design/dop_ifs.sv */
`timescale 1ns / 1ps

interface dop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_last;

  modport source (output valid, output rx_byte, output frame_last, input ready);
  modport sink (input valid, input rx_byte, input frame_last, output ready);
endinterface

interface dop_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] offered_ip;
  logic [31:0] server_ip;
  logic [31:0] net_mask;
  logic [31:0] router_ip;
  logic [31:0] dns_server_ip;

  modport source (output valid, output status, output offered_ip, output server_ip,
                  output net_mask, output router_ip, output dns_server_ip, input ready);
  modport sink (input valid, input status, input offered_ip, input server_ip,
                input net_mask, input router_ip, input dns_server_ip, output ready);
endinterface

interface dop_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] expected_xid;

  modport source (output valid, output expected_xid, input ready);
  modport sink (input valid, input expected_xid, output ready);
endinterface

/* design/dhcp_offer_parser_unit.sv */
`timescale 1ns / 1ps
// DHCP offer parser.
// in_ch carries the received DHCP payload one byte per request, with
// frame_last on the final byte of each frame. cfg_ch writes the expected
// transaction id; it is always ready and should be written while the block
// is idle. out_ch gives one result per frame: a status (ok, first header or
// option error, or truncated when the frame ends before END) and the five
// held addresses as they stand after that byte.
// Throughput is one byte per cycle unless stalled as below. A byte is held in
// the input register and is parsed on its way into the output register, so
// its result is registered there when the byte leaves the input register.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more byte; a byte that would produce a
// further result waits there until the output register is taken, and
// in_ch.ready drops meanwhile. Bytes that produce no result keep flowing.
// Reset clears the parse state, the held addresses and the expected xid,
// and empties both registers.

module dhcp_offer_parser_unit (
  input logic      clk,
  input logic      rst_n,
  dop_in_if.sink   in_ch,
  dop_cfg_if.sink  cfg_ch,
  dop_out_if.source out_ch
);

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  logic [31:0]   xid_r;
  logic          out_valid_r, out_valid_nxt;
  dop_pkg::res_t out_res_r;
  dop_pkg::res_t res;
  logic          step;
  logic          in_acc;

  // advance the input register unless its result would collide with a held one
  assign step   = s1_valid_r && (!res.hit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || step;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  dop_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .xid_i  (xid_r),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (step) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (step && res.hit) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      xid_r       <= 32'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) xid_r <= cfg_ch.expected_xid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.rx_byte;
      s1_last_r <= in_ch.frame_last;
    end
    if (step && res.hit) out_res_r <= res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.offered_ip    = out_res_r.offered_ip;
  assign out_ch.server_ip     = out_res_r.server_ip;
  assign out_ch.net_mask      = out_res_r.net_mask;
  assign out_ch.router_ip     = out_res_r.router_ip;
  assign out_ch.dns_server_ip = out_res_r.dns_server_ip;

endmodule

/* design/dop_parse.sv */
`timescale 1ns / 1ps

module dop_parse (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic [31:0]   xid_i,
  output dop_pkg::res_t res_o
);

  dop_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  hoff_r, hoff_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [31:0] ws_r, ws_nxt;
  logic        sent_r, sent_nxt;
  logic [31:0] offered_r, offered_nxt;
  logic [31:0] server_r, server_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [31:0] router_r, router_nxt;
  logic [31:0] dns_r, dns_nxt;

  logic [31:0] ws_in;
  logic [7:0]  rem_dec;
  logic        found;
  dop_pkg::status_t st;
  logic        hit;
  dop_pkg::status_t status;

  assign ws_in   = {ws_r[23:0], byte_i};
  assign rem_dec = rem_r - 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    hoff_nxt    = hoff_r;
    code_nxt    = code_r;
    rem_nxt     = rem_r;
    ws_nxt      = ws_r;
    sent_nxt    = sent_r;
    offered_nxt = offered_r;
    server_nxt  = server_r;
    mask_nxt    = mask_r;
    router_nxt  = router_r;
    dns_nxt     = dns_r;
    found       = 1'b0;
    st          = dop_pkg::ST_OK;

    // once a result went out, drop bytes until the frame ends
    if (!sent_r) begin
      ws_nxt = ws_in;
      unique case (phase_r)
        dop_pkg::PH_HEADER: begin
          hoff_nxt = hoff_r + 8'd1;
          if (hoff_r == dop_pkg::OFF_OP && byte_i != dop_pkg::BOOTREPLY) begin
            found = 1'b1;
            st    = dop_pkg::ST_OP;
          end else if (hoff_r == dop_pkg::OFF_HTYPE && byte_i != dop_pkg::HTYPE_ETH) begin
            found = 1'b1;
            st    = dop_pkg::ST_HTYPE;
          end else if (hoff_r == dop_pkg::OFF_HLEN && byte_i != dop_pkg::HLEN_ETH) begin
            found = 1'b1;
            st    = dop_pkg::ST_HLEN;
          end else if (hoff_r == dop_pkg::OFF_XID_END && ws_in != xid_i) begin
            found = 1'b1;
            st    = dop_pkg::ST_XID;
          end else if (hoff_r == dop_pkg::OFF_COOKIE_END) begin
            if (ws_in != dop_pkg::COOKIE) begin
              found = 1'b1;
              st    = dop_pkg::ST_COOKIE;
            end else begin
              phase_nxt = dop_pkg::PH_CODE;
            end
          end
          if (hoff_r == dop_pkg::OFF_YIADDR_END) offered_nxt = ws_in;
          if (hoff_r == dop_pkg::OFF_SIADDR_END) server_nxt = ws_in;
        end
        dop_pkg::PH_CODE: begin
          if (byte_i == dop_pkg::OPT_END) begin
            found = 1'b1;
            st    = dop_pkg::ST_OK;
          end else if (byte_i != dop_pkg::OPT_PAD) begin
            code_nxt  = byte_i;
            phase_nxt = dop_pkg::PH_LEN;
          end
        end
        dop_pkg::PH_LEN: begin
          case (code_r) inside
            dop_pkg::OPT_MASK, dop_pkg::OPT_ROUTER, dop_pkg::OPT_DNS,
            dop_pkg::OPT_SERVER_ID, dop_pkg::OPT_LEASE: begin
              if (byte_i != dop_pkg::ADDR_OPT_LEN) begin
                found = 1'b1;
                st    = dop_pkg::ST_OPTLEN;
              end else begin
                rem_nxt   = byte_i;
                phase_nxt = dop_pkg::PH_DATA;
              end
            end
            dop_pkg::OPT_MSG_TYPE: begin
              if (byte_i != dop_pkg::MSG_TYPE_LEN) begin
                found = 1'b1;
                st    = dop_pkg::ST_OPTLEN;
              end else begin
                phase_nxt = dop_pkg::PH_TYPEVAL;
              end
            end
            default: begin
              rem_nxt   = byte_i;
              phase_nxt = (byte_i == 8'd0) ? dop_pkg::PH_CODE : dop_pkg::PH_DATA;
            end
          endcase
        end
        dop_pkg::PH_DATA: begin
          rem_nxt = rem_dec;
          if (rem_dec == 8'd0) begin
            case (code_r)
              dop_pkg::OPT_MASK:      mask_nxt   = ws_in;
              dop_pkg::OPT_ROUTER:    router_nxt = ws_in;
              dop_pkg::OPT_DNS:       dns_nxt    = ws_in;
              dop_pkg::OPT_SERVER_ID: server_nxt = ws_in;
              default: ;
            endcase
            phase_nxt = dop_pkg::PH_CODE;
          end
        end
        dop_pkg::PH_TYPEVAL: begin
          if (byte_i != dop_pkg::MSG_OFFER) begin
            found = 1'b1;
            st    = dop_pkg::ST_TYPE;
          end else begin
            phase_nxt = dop_pkg::PH_CODE;
          end
        end
        dop_pkg::PH_DONE: ;
        default: ;
      endcase
      if (found) begin
        sent_nxt  = 1'b1;
        phase_nxt = dop_pkg::PH_DONE;
      end
    end

    hit    = found;
    status = st;

    // frame end: flag truncation if nothing was reported, then rearm for a new header
    if (last_i) begin
      if (!found && !sent_r) begin
        hit    = 1'b1;
        status = dop_pkg::ST_TRUNC;
      end
      hoff_nxt  = 8'd0;
      phase_nxt = dop_pkg::PH_HEADER;
      code_nxt  = 8'd0;
      rem_nxt   = 8'd0;
      ws_nxt    = 32'd0;
      sent_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= dop_pkg::PH_HEADER;
      hoff_r    <= 8'd0;
      code_r    <= 8'd0;
      rem_r     <= 8'd0;
      ws_r      <= 32'd0;
      sent_r    <= 1'b0;
      offered_r <= 32'd0;
      server_r  <= 32'd0;
      mask_r    <= 32'd0;
      router_r  <= 32'd0;
      dns_r     <= 32'd0;
    end else if (step_i) begin
      phase_r   <= phase_nxt;
      hoff_r    <= hoff_nxt;
      code_r    <= code_nxt;
      rem_r     <= rem_nxt;
      ws_r      <= ws_nxt;
      sent_r    <= sent_nxt;
      offered_r <= offered_nxt;
      server_r  <= server_nxt;
      mask_r    <= mask_nxt;
      router_r  <= router_nxt;
      dns_r     <= dns_nxt;
    end
  end

  assign res_o.hit           = hit;
  assign res_o.status        = status;
  assign res_o.offered_ip    = offered_nxt;
  assign res_o.server_ip     = server_nxt;
  assign res_o.net_mask      = mask_nxt;
  assign res_o.router_ip     = router_nxt;
  assign res_o.dns_server_ip = dns_nxt;

endmodule

/* design/dop_check.sv */
`timescale 1ns / 1ps

module dop_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_status
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 4'(dop_pkg::ST_TRUNC))
    else $error("status code out of range");

  // a fresh result must come from an earlier accepted byte
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching request");

endmodule

bind dhcp_offer_parser_unit dop_check u_dop_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status)
);
